>>> rtl/mcl_pkg.sv
package mcl_pkg;

  localparam int MAX_RADIAL     = 64;
  localparam int MAX_VERTICAL   = 64;
  localparam int MAX_CELLS      = 4096;
  localparam int MAX_PER_COLUMN = 256;

  localparam int RAD_AW  = (MAX_RADIAL > 1) ? $clog2(MAX_RADIAL) : 1;
  localparam int VER_AW  = (MAX_VERTICAL > 1) ? $clog2(MAX_VERTICAL) : 1;
  localparam int CELL_AW = $clog2(MAX_CELLS);
  localparam int CNT_W   = 7;
  localparam int COLX_W  = 2 * CNT_W;
  localparam int DIV_STEPS = 33;
  localparam int DIV_CW    = 6;

  localparam logic [2:0] OP_RADIAL   = 3'd0;
  localparam logic [2:0] OP_VERTICAL = 3'd1;
  localparam logic [2:0] OP_COLUMN   = 3'd2;
  localparam logic [2:0] OP_CELL     = 3'd3;
  localparam logic [2:0] OP_LOCATE   = 3'd4;

  localparam logic [1:0] REG_RADIAL_COUNT   = 2'd0;
  localparam logic [1:0] REG_VERTICAL_COUNT = 2'd1;
  localparam logic [1:0] REG_PHI_PERIOD     = 2'd2;

  localparam logic [30:0] PHI_PERIOD_RST = 31'd411775;

  typedef struct packed {
    logic load_radial;
    logic load_vertical;
    logic load_column;
    logic load_cell;
    logic start;
    logic r_read;
    logic r_cmp;
    logic z_start;
    logic z_read;
    logic z_cmp;
    logic z_end;
    logic col_read;
    logic col_load;
    logic cell_read;
    logic off_load;
    logic div_start;
    logic div_step;
    logic set_hit;
    logic next_cell;
    logic finish;
  } mcl_cmd_t;

  typedef struct packed {
    logic lt;
    logic col_ok;
    logic cell_ok;
    logic need_div;
    logic div_done;
    logic hit;
    logic out_free;
  } mcl_status_t;

endpackage

>>> rtl/mcl_ctrl.sv
module mcl_ctrl import mcl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  mcl_status_t status,
  output mcl_cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_R_CHK  = 4'd1;
  localparam logic [3:0] ST_R_CMP  = 4'd2;
  localparam logic [3:0] ST_Z_CHK  = 4'd3;
  localparam logic [3:0] ST_Z_CMP  = 4'd4;
  localparam logic [3:0] ST_COL    = 4'd5;
  localparam logic [3:0] ST_COL_RD = 4'd6;
  localparam logic [3:0] ST_C_CHK  = 4'd7;
  localparam logic [3:0] ST_C_RD   = 4'd8;
  localparam logic [3:0] ST_C_OFF  = 4'd9;
  localparam logic [3:0] ST_DIV    = 4'd10;
  localparam logic [3:0] ST_C_TEST = 4'd11;
  localparam logic [3:0] ST_DONE   = 4'd12;

  logic [3:0] st_r, st_nxt;
  logic       acc;

  assign in_ready = (st_r == ST_IDLE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    st_nxt = st_r;
    cmd    = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_op)
            OP_RADIAL:   cmd.load_radial   = 1'b1;
            OP_VERTICAL: cmd.load_vertical = 1'b1;
            OP_COLUMN:   cmd.load_column   = 1'b1;
            OP_CELL:     cmd.load_cell     = 1'b1;
            OP_LOCATE: begin
              cmd.start = 1'b1;
              st_nxt    = ST_R_CHK;
            end
            default: ;
          endcase
        end
      end
      ST_R_CHK: begin
        if (status.lt) begin
          cmd.r_read = 1'b1;
          st_nxt     = ST_R_CMP;
        end else begin
          cmd.z_start = 1'b1;
          st_nxt      = ST_Z_CHK;
        end
      end
      ST_R_CMP: begin
        cmd.r_cmp = 1'b1;
        st_nxt    = ST_R_CHK;
      end
      ST_Z_CHK: begin
        if (status.lt) begin
          cmd.z_read = 1'b1;
          st_nxt     = ST_Z_CMP;
        end else begin
          cmd.z_end = 1'b1;
          st_nxt    = ST_COL;
        end
      end
      ST_Z_CMP: begin
        cmd.z_cmp = 1'b1;
        st_nxt    = ST_Z_CHK;
      end
      ST_COL: begin
        if (status.col_ok) begin
          cmd.col_read = 1'b1;
          st_nxt       = ST_COL_RD;
        end else begin
          st_nxt = ST_DONE;
        end
      end
      ST_COL_RD: begin
        cmd.col_load = 1'b1;
        st_nxt       = ST_C_CHK;
      end
      ST_C_CHK: begin
        if (status.cell_ok) begin
          cmd.cell_read = 1'b1;
          st_nxt        = ST_C_RD;
        end else begin
          st_nxt = ST_DONE;
        end
      end
      ST_C_RD: begin
        cmd.off_load = 1'b1;
        st_nxt       = ST_C_OFF;
      end
      ST_C_OFF: begin
        if (status.need_div) begin
          cmd.div_start = 1'b1;
          st_nxt        = ST_DIV;
        end else begin
          st_nxt = ST_C_TEST;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) st_nxt = ST_C_TEST;
      end
      ST_C_TEST: begin
        if (status.hit) begin
          cmd.set_hit = 1'b1;
          st_nxt      = ST_DONE;
        end else begin
          cmd.next_cell = 1'b1;
          st_nxt        = ST_C_CHK;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          st_nxt     = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  a_busy_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !in_ready) else $error("request taken while busy");
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE && status.out_free) |=> (st_r == ST_IDLE))
    else $error("result not handed off");
  a_hit_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_C_TEST && status.hit) |=> (st_r == ST_DONE))
    else $error("scan continued after hit");
  a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV && !status.div_done) |=> (st_r == ST_DIV))
    else $error("remainder left early");

endmodule

>>> rtl/mcl_dp.sv
module mcl_dp import mcl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  mcl_cmd_t           cmd,
  output mcl_status_t        status,
  input  logic [11:0]        in_slot,
  input  logic signed [31:0] in_edge_value,
  input  logic [11:0]        in_first_cell,
  input  logic [8:0]         in_cell_count,
  input  logic signed [31:0] in_upper_phi,
  input  logic [30:0]        in_span_phi,
  input  logic signed [31:0] in_query_r,
  input  logic signed [31:0] in_query_z,
  input  logic signed [31:0] in_query_phi,
  input  logic [CNT_W-1:0]   radial_count,
  input  logic [CNT_W-1:0]   vertical_count,
  input  logic [30:0]        phi_period,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [11:0]        out_cell_index,
  output logic [6:0]         out_radial_index,
  output logic [6:0]         out_vertical_index
);

  logic signed [31:0] radial_mem   [MAX_RADIAL];
  logic signed [31:0] vertical_mem [MAX_VERTICAL];
  logic [11:0]        col_first_mem[MAX_CELLS];
  logic [8:0]         col_size_mem [MAX_CELLS];
  logic signed [31:0] cell_upper_mem[MAX_CELLS];
  logic [30:0]        cell_span_mem[MAX_CELLS];

  logic signed [31:0] qr_r, qz_r, qphi_r;
  logic [CNT_W-1:0]   nr, nz;
  logic [CNT_W-1:0]   lo_r, hi_r, mid_r, j_r, k_r;
  logic [CNT_W-1:0]   mid;
  logic signed [31:0] rad_q, ver_q;
  logic [11:0]        first_q, first_r;
  logic [8:0]         size_q, n_r, i_r;
  logic [COLX_W-1:0]  col;
  logic [12:0]        c;
  logic signed [31:0] upper_q;
  logic [30:0]        span_q, span_r;
  logic signed [32:0] off_r;
  logic [32:0]        dvd_r;
  logic [30:0]        rem_r;
  logic [DIV_CW-1:0]  cnt_r;
  logic [31:0]        trial;
  logic               found_r;
  logic [11:0]        cell_r;
  logic               out_valid_r, out_found_r;
  logic [11:0]        out_cell_r;
  logic [6:0]         out_j_r, out_k_r;

  logic signed [33:0] off_x, off2, pe, rz, m_pos, m_neg0, m_neg, w, spn;
  logic               wrap_hi, wrap_lo;

  assign nr  = (32'(radial_count) > 32'(MAX_RADIAL)) ? CNT_W'(MAX_RADIAL) : radial_count;
  assign nz  = (32'(vertical_count) > 32'(MAX_VERTICAL)) ? CNT_W'(MAX_VERTICAL)
                                                         : vertical_count;
  assign mid = CNT_W'((8'(lo_r) + 8'(hi_r)) >> 1);
  assign col = COLX_W'(j_r) + COLX_W'(nr) * COLX_W'(k_r);
  assign c   = 13'(first_r) + 13'(i_r);

  // table writes
  always_ff @(posedge clk) begin
    if (cmd.load_radial && 32'(in_slot) < 32'(MAX_RADIAL))
      radial_mem[in_slot[RAD_AW-1:0]] <= in_edge_value;
    if (cmd.load_vertical && 32'(in_slot) < 32'(MAX_VERTICAL))
      vertical_mem[in_slot[VER_AW-1:0]] <= in_edge_value;
    if (cmd.load_column && 32'(in_slot) < 32'(MAX_CELLS)) begin
      col_first_mem[in_slot[CELL_AW-1:0]] <= in_first_cell;
      col_size_mem[in_slot[CELL_AW-1:0]]  <= in_cell_count;
    end
    if (cmd.load_cell && 32'(in_slot) < 32'(MAX_CELLS)) begin
      cell_upper_mem[in_slot[CELL_AW-1:0]] <= in_upper_phi;
      cell_span_mem[in_slot[CELL_AW-1:0]]  <= in_span_phi;
    end
  end

  // table reads
  always_ff @(posedge clk) begin
    if (cmd.r_read) rad_q <= radial_mem[mid[RAD_AW-1:0]];
    if (cmd.z_read) ver_q <= vertical_mem[mid[VER_AW-1:0]];
    if (cmd.col_read) begin
      first_q <= col_first_mem[col[CELL_AW-1:0]];
      size_q  <= col_size_mem[col[CELL_AW-1:0]];
    end
    if (cmd.cell_read) begin
      upper_q <= cell_upper_mem[c[CELL_AW-1:0]];
      span_q  <= cell_span_mem[c[CELL_AW-1:0]];
    end
  end

  // binary searches and column scan
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qr_r    <= in_query_r;
      qz_r    <= in_query_z;
      qphi_r  <= in_query_phi;
      lo_r    <= '0;
      hi_r    <= nr;
      found_r <= 1'b0;
      cell_r  <= '0;
      k_r     <= '0;
    end
    if (cmd.r_read || cmd.z_read) mid_r <= mid;
    if (cmd.r_cmp) begin
      if (rad_q < qr_r) lo_r <= mid_r + 1'b1;
      else              hi_r <= mid_r;
    end
    if (cmd.z_start) begin
      j_r  <= lo_r;
      lo_r <= '0;
      hi_r <= nz;
    end
    if (cmd.z_cmp) begin
      if (ver_q < qz_r) lo_r <= mid_r + 1'b1;
      else              hi_r <= mid_r;
    end
    if (cmd.z_end) k_r <= lo_r;
    if (cmd.col_load) begin
      first_r <= first_q;
      n_r     <= (32'(size_q) > 32'(MAX_PER_COLUMN)) ? 9'(MAX_PER_COLUMN) : size_q;
      i_r     <= '0;
    end
    if (cmd.off_load) begin
      off_r  <= 33'(qphi_r) - 33'(upper_q);
      span_r <= span_q;
    end
    if (cmd.next_cell) i_r <= i_r + 1'b1;
    if (cmd.set_hit) begin
      found_r <= 1'b1;
      cell_r  <= c[11:0];
    end
  end

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem_r, dvd_r[32]};
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd_r <= off_r[32] ? 33'(-off_r) : 33'(off_r);
      rem_r <= '0;
      cnt_r <= DIV_CW'(DIV_STEPS);
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[31:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
      if (trial >= {1'b0, phi_period}) rem_r <= 31'(trial - {1'b0, phi_period});
      else                              rem_r <= trial[30:0];
    end
  end

  // wrap the azimuth offset into half a period around zero
  always_comb begin
    off_x   = 34'(off_r);
    off2    = {off_r, 1'b0};
    pe      = {3'b000, phi_period};
    rz      = {3'b000, rem_r};
    spn     = {3'b000, span_r};
    wrap_hi = (phi_period != '0) && (off2 > pe);
    wrap_lo = (phi_period != '0) && (off2 < -pe);
    m_pos   = ({rz[32:0], 1'b0} > pe) ? rz - pe : rz;
    m_neg0  = (rem_r == '0) ? '0 : pe - rz;
    m_neg   = ({m_neg0[32:0], 1'b0} >= pe) ? m_neg0 - pe : m_neg0;
    if (wrap_hi)      w = m_pos;
    else if (wrap_lo) w = m_neg;
    else              w = off_x;
  end

  assign status.lt       = lo_r < hi_r;
  assign status.col_ok   = (j_r < nr) && (k_r < nz) && (32'(col) < 32'(MAX_CELLS));
  assign status.cell_ok  = (i_r < n_r) && (32'(c) < 32'(MAX_CELLS));
  assign status.need_div = wrap_hi || wrap_lo;
  assign status.div_done = (cnt_r == DIV_CW'(1));
  assign status.hit      = w[33] && (w > -spn);
  assign status.out_free = !out_valid_r || out_ready;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_found_r <= found_r;
      out_cell_r  <= cell_r;
      out_j_r     <= j_r;
      out_k_r     <= k_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_cell_index     = out_cell_r;
  assign out_radial_index   = out_j_r;
  assign out_vertical_index = out_k_r;

endmodule

>>> rtl/mesh_cell_locator.sv
// Cell locator for a cylindrical moving mesh.
// Input channel (in_valid/in_ready): one request per op. Ops 0..3 load the
// radial edge, vertical edge, column range and cell tables and
// return nothing. Op 4 locates a particle and returns one result on the
// out_valid/out_ready channel: found flag, flat cell index and the radial
// and vertical search indexes.
// A locate runs two lower-bound searches over the edge memories, one halving
// step at a time, then reads the column entry and scans its cells in turn,
// using the restoring remainder unit for a cell whose offset lies beyond half
// a period.
// One locate is worked on at a time; a load leaves the controller idle, so
// another request can be taken.
// Registers on the APB-style port: radial_count at 0x0, vertical_count at
// 0x4, phi_period at 0x8; write them only while idle.
// Reset returns the controller to idle, clears the result valid flag and
// sets the registers to 64, 64 and 411775; tables stay undefined until loaded.
// A stalled receiver holds the result; the next request is still taken and
// its result waits in the final state until the result register frees.
module mesh_cell_locator import mcl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_op,
  input  logic [11:0]        in_slot,
  input  logic signed [31:0] in_edge_value,
  input  logic [11:0]        in_first_cell,
  input  logic [8:0]         in_cell_count,
  input  logic signed [31:0] in_upper_phi,
  input  logic [30:0]        in_span_phi,
  input  logic signed [31:0] in_query_r,
  input  logic signed [31:0] in_query_z,
  input  logic signed [31:0] in_query_phi,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [11:0]        out_cell_index,
  output logic [6:0]         out_radial_index,
  output logic [6:0]         out_vertical_index
);

  logic [CNT_W-1:0] radial_count_r, vertical_count_r;
  logic [30:0]      phi_period_r;
  logic             wr;
  mcl_cmd_t         cmd;
  mcl_status_t      status;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radial_count_r   <= CNT_W'(MAX_RADIAL);
      vertical_count_r <= CNT_W'(MAX_VERTICAL);
      phi_period_r     <= PHI_PERIOD_RST;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_RADIAL_COUNT:   radial_count_r   <= pwdata[CNT_W-1:0];
        REG_VERTICAL_COUNT: vertical_count_r <= pwdata[CNT_W-1:0];
        REG_PHI_PERIOD:     phi_period_r     <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RADIAL_COUNT:   prdata = 32'(radial_count_r);
      REG_VERTICAL_COUNT: prdata = 32'(vertical_count_r);
      REG_PHI_PERIOD:     prdata = 32'(phi_period_r);
      default:            prdata = '0;
    endcase
  end

  mcl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .status   (status),
    .cmd      (cmd)
  );

  mcl_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_slot            (in_slot),
    .in_edge_value      (in_edge_value),
    .in_first_cell      (in_first_cell),
    .in_cell_count      (in_cell_count),
    .in_upper_phi       (in_upper_phi),
    .in_span_phi        (in_span_phi),
    .in_query_r         (in_query_r),
    .in_query_z         (in_query_z),
    .in_query_phi       (in_query_phi),
    .radial_count       (radial_count_r),
    .vertical_count     (vertical_count_r),
    .phi_period         (phi_period_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_cell_index     (out_cell_index),
    .out_radial_index   (out_radial_index),
    .out_vertical_index (out_vertical_index)
  );

endmodule

>>> verif/tb_mesh_cell_locator.sv
module tb_mesh_cell_locator;
  import mcl_pkg::*;

  localparam int WATCHDOG_CYCLES = 60000;
  localparam int PHASE_ITEMS     = 190;
  // the fill test loads only the low columns; column ranges stay inside the two
  // cell windows at the bottom and the top of the cell table
  localparam int COLS_USED       = 128;
  localparam int CELL_WIN        = 128;

  typedef struct {
    logic [2:0]         op;
    logic [11:0]        slot;
    logic signed [31:0] edge_v;
    logic [11:0]        first;
    logic [8:0]         count;
    logic signed [31:0] upper;
    logic [30:0]        span;
    logic signed [31:0] qr;
    logic signed [31:0] qz;
    logic signed [31:0] qphi;
  } mesh_req_t;

  typedef struct packed {
    logic        found;
    logic [11:0] cell_idx;
    logic [6:0]  ri;
    logic [6:0]  vi;
  } locate_res_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_op = '0;
  logic [11:0]        in_slot = '0;
  logic signed [31:0] in_edge_value = '0;
  logic [11:0]        in_first_cell = '0;
  logic [8:0]         in_cell_count = '0;
  logic signed [31:0] in_upper_phi = '0;
  logic [30:0]        in_span_phi = '0;
  logic signed [31:0] in_query_r = '0, in_query_z = '0, in_query_phi = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_found;
  logic [11:0]        out_cell_index;
  logic [6:0]         out_radial_index, out_vertical_index;

  mesh_cell_locator DUT (.*);

  always #6 clk = ~clk;

  // predicted copy of the block's tables and registers
  logic signed [31:0] radial_tab [MAX_RADIAL];
  logic signed [31:0] vertical_tab [MAX_VERTICAL];
  logic [11:0]        col_first_tab [MAX_CELLS];
  logic [8:0]         col_size_tab [MAX_CELLS];
  logic signed [31:0] cell_upper_tab [MAX_CELLS];
  logic [30:0]        cell_span_tab [MAX_CELLS];
  logic [6:0]         radial_cnt = 7'd64, vertical_cnt = 7'd64;
  logic [30:0]        period = PHI_PERIOD_RST;

  locate_res_t pending_locates[$];
  int          errors = 0;
  int          idle_pct = 0, stall_pct = 0;
  int          hold_cycles = 0;
  int          quiet_cycles = 0;
  int          radial_step = 1, vertical_step = 1;

  function automatic int lower_bound_edge(bit vert, int n, logic signed [31:0] key);
    int lo, hi, mid;
    logic signed [31:0] v;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      v = vert ? vertical_tab[mid] : radial_tab[mid];
      if (v < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic longint wrap_phi(longint off, longint p);
    longint m;
    if (p == 0) return off;
    if (2 * off > p) begin
      m = off % p;
      if (m < 0) m += p;
      if (2 * m > p) m -= p;
      return m;
    end
    if (2 * off < -p) begin
      m = off % p;
      if (m < 0) m += p;
      if (2 * m >= p) m -= p;
      return m;
    end
    return off;
  endfunction

  function automatic locate_res_t predict_locate(mesh_req_t r);
    locate_res_t res;
    int nr, nz, j, k, col, n, c;
    longint off;
    nr = (radial_cnt > MAX_RADIAL) ? MAX_RADIAL : radial_cnt;
    nz = (vertical_cnt > MAX_VERTICAL) ? MAX_VERTICAL : vertical_cnt;
    j = lower_bound_edge(1'b0, nr, r.qr);
    k = lower_bound_edge(1'b1, nz, r.qz);
    res = '0;
    res.ri = j[6:0];
    res.vi = k[6:0];
    if (j < nr && k < nz) begin
      col = j + nr * k;
      if (col < MAX_CELLS) begin
        n = col_size_tab[col];
        if (n > MAX_PER_COLUMN) n = MAX_PER_COLUMN;
        for (int i = 0; i < n; i++) begin
          c = col_first_tab[col] + i;
          if (c >= MAX_CELLS) break;
          off = wrap_phi(longint'(r.qphi) - longint'(cell_upper_tab[c]), longint'(period));
          if (-longint'(cell_span_tab[c]) < off && off < 0) begin
            res.found = 1'b1;
            res.cell_idx = c[11:0];
            break;
          end
        end
      end
    end
    return res;
  endfunction

  function automatic void apply_request(mesh_req_t r);
    case (r.op)
      OP_RADIAL:   if (r.slot < MAX_RADIAL) radial_tab[r.slot] = r.edge_v;
      OP_VERTICAL: if (r.slot < MAX_VERTICAL) vertical_tab[r.slot] = r.edge_v;
      OP_COLUMN: if (r.slot < MAX_CELLS) begin
        col_first_tab[r.slot] = r.first;
        col_size_tab[r.slot] = r.count;
      end
      OP_CELL: if (r.slot < MAX_CELLS) begin
        cell_upper_tab[r.slot] = r.upper;
        cell_span_tab[r.slot] = r.span;
      end
      OP_LOCATE: pending_locates.push_back(predict_locate(r));
      default: ;
    endcase
  endfunction

  function automatic mesh_req_t noise_request(logic [2:0] op);
    mesh_req_t r;
    r.op = op;
    r.slot = 12'($urandom);
    r.edge_v = $urandom;
    r.first = 12'($urandom);
    r.count = 9'($urandom);
    r.upper = $urandom;
    r.span = 31'($urandom);
    r.qr = $urandom;
    r.qz = $urandom;
    r.qphi = $urandom;
    return r;
  endfunction

  // first cell of a short column, inside one of the loaded cell windows
  function automatic logic [31:0] pick_first();
    logic [31:0] f;
    if ($urandom_range(1)) f = $urandom_range(0, CELL_WIN - 9);
    else f = $urandom_range(MAX_CELLS - CELL_WIN, MAX_CELLS - 1);
    return f;
  endfunction

  // enter and leave at a falling edge
  task automatic send_request(mesh_req_t r);
    int gap;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op <= r.op;
    in_slot <= r.slot;
    in_edge_value <= r.edge_v;
    in_first_cell <= r.first;
    in_cell_count <= r.count;
    in_upper_phi <= r.upper;
    in_span_phi <= r.span;
    in_query_r <= r.qr;
    in_query_z <= r.qz;
    in_query_phi <= r.qphi;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    apply_request(r);
    @(negedge clk);
  endtask

  task automatic load_entry(logic [2:0] op, int slot, logic [31:0] a, logic [31:0] b);
    mesh_req_t r;
    r = noise_request(op);
    r.slot = 12'(slot);
    r.edge_v = a;
    r.first = a[11:0];
    r.count = b[8:0];
    r.upper = a;
    r.span = b[30:0];
    send_request(r);
  endtask

  task automatic locate(logic [31:0] qr, logic [31:0] qz, logic [31:0] qphi);
    mesh_req_t r;
    r = noise_request(OP_LOCATE);
    r.qr = qr;
    r.qz = qz;
    r.qphi = qphi;
    send_request(r);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_locates.size() > 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RADIAL_COUNT:   radial_cnt = value[6:0];
      REG_VERTICAL_COUNT: vertical_cnt = value[6:0];
      REG_PHI_PERIOD:     period = value[30:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int rc, int zc, logic [31:0] p);
    drain_results();
    cfg_write(REG_RADIAL_COUNT, rc);
    cfg_write(REG_VERTICAL_COUNT, zc);
    cfg_write(REG_PHI_PERIOD, p);
  endtask

  // sorted edges so that searches land on every index
  task automatic fill_edges();
    logic signed [31:0] base;
    radial_step = $urandom_range(1, 32'h0100_0000);
    vertical_step = $urandom_range(1, 32'h0100_0000);
    base = -$signed($urandom_range(0, 32'h4000_0000));
    for (int i = 0; i < MAX_RADIAL; i++) load_entry(OP_RADIAL, i, base + i * radial_step, 0);
    base = -$signed($urandom_range(0, 32'h4000_0000));
    for (int i = 0; i < MAX_VERTICAL; i++)
      load_entry(OP_VERTICAL, i, base + i * vertical_step, 0);
  endtask

  task automatic test_fill_tables();
    fill_edges();
    for (int i = 0; i < COLS_USED; i++)
      load_entry(OP_COLUMN, i, pick_first(), $urandom_range(0, 6));
    for (int i = 0; i < CELL_WIN; i++) begin
      load_entry(OP_CELL, i, $urandom,
                 $urandom_range(1) ? $urandom_range(0, 32'h0010_0000) : $urandom);
      load_entry(OP_CELL, MAX_CELLS - 1 - i, $urandom,
                 $urandom_range(1) ? $urandom_range(0, 32'h0010_0000) : $urandom);
    end
  endtask

  task automatic test_directed();
    set_config(64, 64, PHI_PERIOD_RST);
    load_entry(OP_RADIAL, 0, 32'h8000_0000, 0);
    load_entry(OP_RADIAL, 63, 32'h7FFF_FFFF, 0);
    load_entry(OP_RADIAL, 4095, 32'hFFFF_FFFF, 0);
    load_entry(OP_VERTICAL, 64, 32'hFFFF_FFFF, 0);
    locate(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    locate(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    for (int op = 5; op < 8; op++) send_request(noise_request(3'(op)));
    // long column, clamped and cut off at the end of the cell table
    load_entry(OP_COLUMN, 0, 4090, 511);
    load_entry(OP_CELL, 4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    locate(radial_tab[0], vertical_tab[0], 32'h8000_0000);
    load_entry(OP_COLUMN, 0, MAX_CELLS - CELL_WIN, 256);
    locate(radial_tab[0], vertical_tab[0], $urandom);
    // half-period ties
    set_config(64, 64, 1000);
    load_entry(OP_COLUMN, 0, 100, 1);
    load_entry(OP_CELL, 100, 0, 600);
    locate(radial_tab[0], vertical_tab[0], 500);
    locate(radial_tab[0], vertical_tab[0], -500);
    locate(radial_tab[0], vertical_tab[0], 1500);
    locate(radial_tab[0], vertical_tab[0], -1500);
    set_config(64, 64, 0);
    locate(radial_tab[0], vertical_tab[0], -5);
    locate(radial_tab[0], vertical_tab[0], 1500);
    set_config(0, 0, 32'h7FFF_FFFF);
    locate($urandom, $urandom, $urandom);
    set_config(127, 127, 999);
    locate(radial_tab[5], vertical_tab[1], $urandom);
    test_fill_tables_edges_only();
  endtask

  task automatic test_fill_tables_edges_only();
    fill_edges();
  endtask

  task automatic send_aimed_locate();
    mesh_req_t r;
    int nr, nz, j, k, col, c, m;
    logic [31:0] lim;
    longint t;
    r = noise_request(OP_LOCATE);
    nr = (radial_cnt > MAX_RADIAL) ? MAX_RADIAL : radial_cnt;
    nz = (vertical_cnt > MAX_VERTICAL) ? MAX_VERTICAL : vertical_cnt;
    j = ($urandom_range(9) == 0) ? nr : $urandom_range(0, nr - 1);
    k = ($urandom_range(9) == 0) ? nz : $urandom_range(0, nz - 1);
    r.qr = (j < nr) ? radial_tab[j] - $urandom_range(0, radial_step - 1)
                    : radial_tab[nr - 1] + 1 + $urandom_range(0, 1000);
    r.qz = (k < nz) ? vertical_tab[k] - $urandom_range(0, vertical_step - 1)
                    : vertical_tab[nz - 1] + 1 + $urandom_range(0, 1000);
    if (j < nr && k < nz) begin
      col = j + nr * k;
      if (col_size_tab[col] > 0) begin
        c = col_first_tab[col] + $urandom_range(0, col_size_tab[col] - 1);
        if (c >= MAX_CELLS) c = MAX_CELLS - 1;
        m = $urandom_range(0, 4) - 2;
        lim = cell_span_tab[c] + 2;
        t = longint'(cell_upper_tab[c]) + longint'(m) * longint'(period)
            - longint'($urandom_range(0, lim));
        r.qphi = t[31:0];
      end
    end
    send_request(r);
  endtask

  task automatic test_random_phase(int rc, int zc, logic [31:0] p, int ipct, int spct);
    mesh_req_t r;
    int pick;
    set_config(rc, zc, p);
    idle_pct = ipct;
    stall_pct = spct;
    fill_edges();
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      pick = $urandom_range(99);
      if (pick < 45) send_aimed_locate();
      else if (pick < 55) send_request(noise_request(OP_LOCATE));
      else if (pick < 75) begin
        r = noise_request(OP_CELL);
        if ($urandom_range(1)) r.span = 31'($urandom_range(0, 32'h0010_0000));
        send_request(r);
      end else if (pick < 88) begin
        r = noise_request(OP_COLUMN);
        r.first = 12'(pick_first());
        r.count = 9'($urandom_range(0, 8));
        send_request(r);
      end else if (pick < 94) begin
        r = noise_request($urandom_range(1) ? OP_RADIAL : OP_VERTICAL);
        r.slot = 12'($urandom_range(0, 127));
        send_request(r);
      end else send_request(noise_request(3'($urandom_range(5, 7))));
    end
  endtask

  task automatic test_backpressure();
    set_config(16, 8, PHI_PERIOD_RST);
    idle_pct = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_cycles = 400;
    @(negedge clk);
    for (int n = 0; n < 12; n++) send_aimed_locate();
    // wait for every result before going on
    drain_results();
    for (int n = 0; n < 8; n++) send_aimed_locate();
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    locate_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_locates.size() == 0) begin
        errors++;
        $display("%0t: unexpected result found=%0d cell=%0d r=%0d z=%0d", $time,
                 out_found, out_cell_index, out_radial_index, out_vertical_index);
      end else begin
        want = pending_locates.pop_front();
        if (out_found !== want.found) begin
          errors++;
          $display("%0t: found expected %0d actual %0d", $time, want.found, out_found);
        end
        if (out_cell_index !== want.cell_idx) begin
          errors++;
          $display("%0t: cell_index expected %0d actual %0d", $time, want.cell_idx,
                   out_cell_index);
        end
        if (out_radial_index !== want.ri) begin
          errors++;
          $display("%0t: radial_index expected %0d actual %0d", $time, want.ri,
                   out_radial_index);
        end
        if (out_vertical_index !== want.vi) begin
          errors++;
          $display("%0t: vertical_index expected %0d actual %0d", $time, want.vi,
                   out_vertical_index);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_fill_tables();
    test_directed();
    test_random_phase(16, 8, PHI_PERIOD_RST, 0, 0);
    test_random_phase(5, 12, $urandom_range(1, 32'h0010_0000), 80, 0);
    test_random_phase(1, 64, 32'h7FFF_FFFF, 0, 80);
    test_random_phase(127, 2, $urandom_range(1, 32'h0100_0000), 32, 32);
    test_backpressure();
    drain_results();
    repeat (100) @(negedge clk);
    if (errors == 0 && pending_locates.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
